// ----- hdl/sgfd_pkg.sv -----
package sgfd_pkg;

    // Input operation codes.
    localparam logic [1:0] OP_BYTE     = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_OVERFLOW = 2'd2;
    localparam logic [1:0] OP_FULL     = 2'd3;

    // Reasons reported with a closed frame.
    localparam logic [2:0] REASON_GAP      = 3'd0;
    localparam logic [2:0] REASON_SYNC     = 3'd1;
    localparam logic [2:0] REASON_IDLE     = 3'd2;
    localparam logic [2:0] REASON_OVERFLOW = 3'd3;
    localparam logic [2:0] REASON_FULL     = 3'd4;

    // Configuration register indexes.
    localparam logic REG_IDLE_GAP = 1'b0;
    localparam logic REG_SYNC     = 1'b1;

    // Configuration reset values.
    localparam logic [31:0] IDLE_GAP_RESET = 32'd20000;
    localparam logic [7:0]  SYNC_RESET     = 8'hAA;

    // Field widths fixed by the interface.
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 7;
    localparam int REASON_W = 3;
    localparam int STAMP_W  = 32;
    localparam int CNT_W    = 32;

endpackage

// ----- hdl/sgfd_frame_ram.sv -----
module sgfd_frame_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/sync_gap_frame_delimiter_top.sv -----
// Frame delimiter for a received byte stream. Each input beat is a timestamped
// byte, a time tick, or an overflow or buffer-full event. Bytes collect in a
// frame buffer of FRAME_BYTES entries; the open frame closes on a gap longer
// than idle_gap_limit before a byte, on a sync byte once the frame holds more
// than one byte, on a tick that finds the line idle past the limit, or on an
// overflow or buffer-full event. A closed frame leaves as one output beat per
// stored byte, each carrying the reason, length, times and running counters;
// a frame made of a lone sync byte is dropped and counted instead. The block
// takes one input beat at a time. Each beat is latched and then evaluated; a
// byte is stored after that. A beat that emits a frame first reads it out,
// held back by output stalls, and a byte that closed it is stored after the
// readout. The readout rate of one byte per cycle while out_ready is high is
// set by the single read port of the frame buffer. Configuration writes are
// taken at any time with cfg_write and must only occur while idle.
module sync_gap_frame_delimiter_top #(
    parameter int FRAME_BYTES = 64,
    parameter int TIME_BITS   = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [31:0]                 cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  opcode,
    input  logic [sgfd_pkg::BYTE_W-1:0] rx_byte,
    input  logic [31:0]                 time_us,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sgfd_pkg::BYTE_W-1:0]   frame_byte,
    output logic [sgfd_pkg::POS_W-1:0]    byte_position,
    output logic                          end_of_frame,
    output logic [sgfd_pkg::REASON_W-1:0] close_reason,
    output logic [sgfd_pkg::LEN_W-1:0]    frame_length,
    output logic [sgfd_pkg::STAMP_W-1:0]  start_time,
    output logic [sgfd_pkg::STAMP_W-1:0]  end_time,
    output logic [sgfd_pkg::CNT_W-1:0]    frames_seen,
    output logic [sgfd_pkg::CNT_W-1:0]    lone_sync_count,
    output logic [sgfd_pkg::CNT_W-1:0]    dropped_bytes
);

    import sgfd_pkg::*;

    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int AW = $clog2(FRAME_BYTES);
    localparam int TB = TIME_BITS;
    localparam int GW = (TIME_BITS > 32) ? TIME_BITS : 32;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_SEND  = 4'b0100,
        S_STORE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration.
    logic [31:0] limit_reg;
    logic [7:0]  sync_reg;

    // Latched input beat.
    logic [1:0]    op_reg, op_next;
    logic [7:0]    byte_reg, byte_next;
    logic [TB-1:0] now_reg, now_next;

    // Frame state.
    logic [CW-1:0] count_reg, count_next;
    logic [TB-1:0] first_time_reg, first_time_next;
    logic [TB-1:0] last_time_reg, last_time_next;
    logic [7:0]    first_byte_reg, first_byte_next;
    logic [31:0]   frame_total_reg, frame_total_next;
    logic [31:0]   lone_total_reg, lone_total_next;
    logic [31:0]   drop_total_reg, drop_total_next;

    // Readout of a closed frame.
    logic [CW-1:0]       len_reg, len_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [REASON_W-1:0] reason_reg, reason_next;
    logic [TB-1:0]       start_reg, start_next;

    // Frame buffer ports.
    logic          ram_wr;
    logic          ram_rd;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    // Shared gap unit: wrapping difference, unsigned compare with the limit.
    logic [TB-1:0] gap;
    logic          gap_over;
    logic [GW-1:0] now_wide;
    logic [GW-1:0] start_wide;
    logic [GW-1:0] end_wide;

    // Close decision in the evaluation cycle.
    logic                close_req;
    logic [REASON_W-1:0] close_why;
    logic                is_last;

    assign now_wide   = GW'(time_us);
    assign gap        = now_reg - last_time_reg;
    assign gap_over   = GW'(gap) > GW'(limit_reg);
    assign start_wide = GW'(start_reg);
    assign end_wide   = GW'(last_time_reg);
    assign is_last    = (CW'(idx_reg) + CW'(1)) == len_reg;

    sgfd_frame_ram #(
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (byte_reg),
        .rd_en   (ram_rd),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= IDLE_GAP_RESET;
            sync_reg  <= SYNC_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IDLE_GAP: limit_reg <= cfg_data;
                REG_SYNC:     sync_reg  <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    // Close decision for the latched beat.
    always_comb
    begin
        close_req = 1'b0;
        close_why = REASON_GAP;
        case (op_reg)
            OP_BYTE:
            begin
                if (count_reg != '0 && gap_over)
                begin
                    close_req = 1'b1;
                    close_why = REASON_GAP;
                end
                else if (count_reg > CW'(1) && byte_reg == sync_reg)
                begin
                    close_req = 1'b1;
                    close_why = REASON_SYNC;
                end
            end
            OP_TICK:
            begin
                close_req = (count_reg != '0) && gap_over;
                close_why = REASON_IDLE;
            end
            OP_OVERFLOW:
            begin
                close_req = 1'b1;
                close_why = REASON_OVERFLOW;
            end
            OP_FULL:
            begin
                close_req = 1'b1;
                close_why = REASON_FULL;
            end
            default:
            begin
                close_req = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        byte_next        = byte_reg;
        now_next         = now_reg;
        count_next       = count_reg;
        first_time_next  = first_time_reg;
        last_time_next   = last_time_reg;
        first_byte_next  = first_byte_reg;
        frame_total_next = frame_total_reg;
        lone_total_next  = lone_total_reg;
        drop_total_next  = drop_total_reg;
        len_next         = len_reg;
        idx_next         = idx_reg;
        reason_next      = reason_reg;
        start_next       = start_reg;
        ram_wr           = 1'b0;
        ram_rd           = 1'b0;
        ram_rd_addr      = idx_reg + AW'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    byte_next  = rx_byte;
                    now_next   = now_wide[TB-1:0];
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                state_next = (op_reg == OP_BYTE) ? S_STORE : S_IDLE;
                if (close_req && count_reg != '0)
                begin
                    count_next      = '0;
                    first_time_next = '0;
                    if (count_reg == CW'(1) && first_byte_reg == sync_reg)
                    begin
                        // A lone sync byte is dropped and counted.
                        lone_total_next = lone_total_reg + 32'd1;
                    end
                    else
                    begin
                        // Start the readout with a read of the first byte.
                        frame_total_next = frame_total_reg + 32'd1;
                        len_next         = count_reg;
                        reason_next      = close_why;
                        start_next       = first_time_reg;
                        idx_next         = '0;
                        ram_rd           = 1'b1;
                        ram_rd_addr      = '0;
                        state_next       = S_SEND;
                    end
                end
            end

            S_SEND:
            begin
                if (out_ready)
                begin
                    if (is_last)
                    begin
                        state_next = (op_reg == OP_BYTE) ? S_STORE : S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                        ram_rd   = 1'b1;
                    end
                end
            end

            S_STORE:
            begin
                if (count_reg == '0)
                begin
                    first_time_next = now_reg;
                    first_byte_next = byte_reg;
                end
                if (count_reg < CW'(FRAME_BYTES))
                begin
                    ram_wr     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    drop_total_next = drop_total_reg + 32'd1;
                end
                last_time_next = now_reg;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            first_time_reg  <= '0;
            last_time_reg   <= '0;
            frame_total_reg <= '0;
            lone_total_reg  <= '0;
            drop_total_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            first_time_reg  <= first_time_next;
            last_time_reg   <= last_time_next;
            frame_total_reg <= frame_total_next;
            lone_total_reg  <= lone_total_next;
            drop_total_reg  <= drop_total_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        byte_reg       <= byte_next;
        now_reg        <= now_next;
        first_byte_reg <= first_byte_next;
        len_reg        <= len_next;
        idx_reg        <= idx_next;
        reason_reg     <= reason_next;
        start_reg      <= start_next;
    end

    // Ports.
    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = (state_reg == S_SEND);
    assign frame_byte      = ram_rd_data;
    assign byte_position   = POS_W'(idx_reg);
    assign end_of_frame    = is_last;
    assign close_reason    = reason_reg;
    assign frame_length    = LEN_W'(len_reg);
    assign start_time      = start_wide[31:0];
    assign end_time        = end_wide[31:0];
    assign frames_seen     = frame_total_reg;
    assign lone_sync_count = lone_total_reg;
    assign dropped_bytes   = drop_total_reg;

    // The input and output sides are never open at once.
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a frame beat is offered");

    // The fill count never passes the buffer size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(FRAME_BYTES))
        else $error("frame fill count beyond buffer size");

    // A frame beat always lies inside its frame.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (LEN_W'(byte_position) < frame_length))
        else $error("byte position outside frame length");

    // The readout ends right after the last beat is taken.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && end_of_frame) |=> !out_valid)
        else $error("frame beats continue after end of frame");

    // Within a run, positions step by one per beat taken.
    a_run_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !end_of_frame) |=>
            (out_valid && byte_position == $past(byte_position) + POS_W'(1)))
        else $error("byte position did not advance by one");

endmodule
